// ----- rtl/core/swp_pkg.sv -----
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types, codes and segment encoding for the spot-weld pulse controller.
// ----------------------------------------------------------------------------
package swp_pkg;

  localparam int AdcWidth      = 10;
  localparam int SetpointWidth = 10;
  localparam int CountWidth    = 14;
  localparam int CfgDataWidth  = 12;
  localparam int CfgIndexWidth = 3;

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_TRIGGER = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_OFFSET = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_WELD_UNIT     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_GAP           = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SECOND_PULSE  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_HOLD          = 3'd4;

  localparam logic [7:0]  RST_SAMPLE_OFFSET = 8'd30;
  localparam logic [3:0]  RST_WELD_UNIT     = 4'd10;
  localparam logic [7:0]  RST_GAP           = 8'd2;
  localparam logic [7:0]  RST_SECOND_PULSE  = 8'd5;
  localparam logic [11:0] RST_HOLD          = 12'd1000;

  localparam logic [7:0] SEG_DOT_MASK = 8'h7F;
  localparam logic [7:0] SEG_BLANK    = 8'hFF;

  typedef struct packed {
    logic                     buzzer;
    logic                     contactor;
    logic                     second;
    logic                     busy;
    logic [SetpointWidth-1:0] setpoint;
  } swp_snap_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b11000000;
      4'd1: code = 8'b11111001;
      4'd2: code = 8'b10100100;
      4'd3: code = 8'b10110000;
      4'd4: code = 8'b10011001;
      4'd5: code = 8'b10010010;
      4'd6: code = 8'b10000010;
      4'd7: code = 8'b11111000;
      4'd8: code = 8'b10000000;
      4'd9: code = 8'b10010000;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/swp_ctrl.sv -----
// ----------------------------------------------------------------------------
// swp_ctrl
// Configuration registers, setpoint scaling and weld sequence state.
// ----------------------------------------------------------------------------
module swp_ctrl import swp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     step,
  input  logic [1:0]               func,
  input  logic [AdcWidth-1:0]      adc_value,
  output swp_snap_t                snap
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WELD,
    PH_GAP,
    PH_SECOND,
    PH_HOLD
  } phase_t;

  logic [7:0]  sample_offset;
  logic [3:0]  weld_unit_ticks;
  logic [7:0]  gap_ticks;
  logic [7:0]  second_pulse_ticks;
  logic [11:0] hold_ticks;

  phase_t                   phase, phase_next;
  logic [CountWidth-1:0]    phase_count, phase_count_next;
  logic                     alternate_flag, alternate_flag_next;
  logic                     pending_trigger, pending_trigger_next;
  logic [SetpointWidth-1:0] setpoint, setpoint_next;
  swp_snap_t                snap_next;

  logic [CountWidth-1:0]    weld_len;
  phase_t                   adv_phase;
  logic [CountWidth-1:0]    adv_count;
  logic                     adv_done;

  logic [AdcWidth:0]        adc_ceil_arg;
  logic [21:0]              adc_prod;
  logic [4:0]               adc_quot;
  logic [AdcWidth-1:0]      scaled;
  logic [SetpointWidth-1:0] sample_value;

  // floor(adc*40/41) = adc - ceil(adc/41); divide by 41 through 1599/65536
  always_comb begin
    adc_ceil_arg = {1'b0, adc_value} + 11'd40;
    adc_prod     = {11'd0, adc_ceil_arg} * 22'd1599;
    adc_quot     = adc_prod[20:16];
    scaled       = adc_value - {5'd0, adc_quot};
    if (scaled > {2'd0, sample_offset}) begin
      sample_value = scaled - {2'd0, sample_offset};
    end else begin
      sample_value = '0;
    end
  end

  assign weld_len = {4'd0, setpoint} * {10'd0, weld_unit_ticks};

  // next non-empty phase after the current one
  always_comb begin
    adv_done  = 1'b1;
    adv_phase = PH_IDLE;
    adv_count = '0;
    if (phase == PH_IDLE && weld_len != '0) begin
      adv_done  = 1'b0;
      adv_phase = PH_WELD;
      adv_count = weld_len;
    end else if ((phase == PH_IDLE || phase == PH_WELD) && gap_ticks != '0) begin
      adv_done  = 1'b0;
      adv_phase = PH_GAP;
      adv_count = {6'd0, gap_ticks};
    end else if ((phase == PH_IDLE || phase == PH_WELD || phase == PH_GAP) &&
                 second_pulse_ticks != '0) begin
      adv_done  = 1'b0;
      adv_phase = PH_SECOND;
      adv_count = {6'd0, second_pulse_ticks};
    end else if (phase != PH_HOLD && hold_ticks != '0) begin
      adv_done  = 1'b0;
      adv_phase = PH_HOLD;
      adv_count = {2'd0, hold_ticks};
    end
  end

  always_comb begin
    phase_next           = phase;
    phase_count_next     = phase_count;
    alternate_flag_next  = alternate_flag;
    pending_trigger_next = pending_trigger;
    setpoint_next        = setpoint;
    case (func)
      FUNC_SAMPLE: begin
        if (phase == PH_IDLE) begin
          setpoint_next = sample_value;
        end
      end
      FUNC_TRIGGER: begin
        if (phase != PH_IDLE) begin
          pending_trigger_next = 1'b1;
        end else if (!alternate_flag) begin
          if (adv_done) begin
            alternate_flag_next = 1'b1;
          end else begin
            phase_next       = adv_phase;
            phase_count_next = adv_count;
          end
        end else begin
          alternate_flag_next = 1'b0;
        end
      end
      FUNC_TICK: begin
        if (phase != PH_IDLE) begin
          if (phase_count > 14'd1) begin
            phase_count_next = phase_count - 14'd1;
          end else if (!adv_done) begin
            phase_next       = adv_phase;
            phase_count_next = adv_count;
          end else begin
            phase_next           = PH_IDLE;
            phase_count_next     = '0;
            pending_trigger_next = 1'b0;
            alternate_flag_next  = !pending_trigger;
          end
        end
      end
      default: begin
      end
    endcase
    snap_next.buzzer    = (phase_next == PH_WELD);
    snap_next.contactor = (phase_next != PH_WELD);
    snap_next.second    = (phase_next == PH_SECOND);
    snap_next.busy      = (phase_next != PH_IDLE);
    snap_next.setpoint  = setpoint_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset      <= RST_SAMPLE_OFFSET;
      weld_unit_ticks    <= RST_WELD_UNIT;
      gap_ticks          <= RST_GAP;
      second_pulse_ticks <= RST_SECOND_PULSE;
      hold_ticks         <= RST_HOLD;
      phase              <= PH_IDLE;
      phase_count        <= '0;
      alternate_flag     <= 1'b0;
      pending_trigger    <= 1'b0;
      setpoint           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_OFFSET: sample_offset      <= cfg_data[7:0];
          CFG_WELD_UNIT:     weld_unit_ticks    <= cfg_data[3:0];
          CFG_GAP:           gap_ticks          <= cfg_data[7:0];
          CFG_SECOND_PULSE:  second_pulse_ticks <= cfg_data[7:0];
          CFG_HOLD:          hold_ticks         <= cfg_data[11:0];
          default: begin
          end
        endcase
      end
      if (step) begin
        phase           <= phase_next;
        phase_count     <= phase_count_next;
        alternate_flag  <= alternate_flag_next;
        pending_trigger <= pending_trigger_next;
        setpoint        <= setpoint_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      snap <= snap_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> phase_count != '0)
    else $error("running phase with empty count");

  assert property (@(posedge clk) disable iff (rst)
    pending_trigger |-> phase != PH_IDLE)
    else $error("trigger held while idle");

  assert property (@(posedge clk) disable iff (rst)
    setpoint <= 10'd998)
    else $error("setpoint out of range");

  assert property (@(posedge clk) disable iff (rst)
    step && phase != PH_IDLE |=> $stable(setpoint))
    else $error("setpoint changed during sequence");

endmodule

// ----- rtl/core/swp_disp.sv -----
// ----------------------------------------------------------------------------
// swp_disp
// Digit split, seven-segment encoding and result register.
// ----------------------------------------------------------------------------
module swp_disp import swp_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  swp_snap_t snap,
  output swp_snap_t res,
  output logic [7:0] seg_hundreds,
  output logic [7:0] seg_tens,
  output logic [7:0] seg_ones
);

  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [6:0]  rem_tens;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  // v/100 = (v*41)>>12 and r/10 = (r*205)>>11 over these ranges
  always_comb begin
    hund_prod = {6'd0, snap.setpoint} * 16'd41;
    hund      = hund_prod[15:12];
    rem_tens  = 7'(snap.setpoint - {6'd0, hund} * 10'd100);
    tens_prod = {8'd0, rem_tens} * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem_tens - {3'd0, tens} * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res          <= snap;
      seg_hundreds <= seg_code(hund) & SEG_DOT_MASK;
      seg_tens     <= seg_code(tens);
      seg_ones     <= seg_code(ones);
    end
  end

endmodule

// ----- rtl/core/spot_weld_pulse_controller_core.sv -----
// ----------------------------------------------------------------------------
// spot_weld_pulse_controller_core
// Spot-weld timing controller with setpoint scaling and segment display codes.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall and passes it
// through three stage registers: an input register, a control stage that
// updates the weld sequence state and setpoint, and a display stage that
// splits the setpoint into digits and encodes segments. Stalls on the result
// side back up through the three stage registers; the sequence state
// advances once per item.
module spot_weld_pulse_controller_core import swp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [15:0]              s_tdata,  // adc_value[9:0], zero pad
  input  logic [1:0]               s_tuser,  // func[1:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [39:0]              m_tdata,  // buzzer_out, contactor_out, second_out,
                                             // busy_res, setpoint_value[9:0],
                                             // seg_hundreds, seg_tens, seg_ones, pad
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  logic                in_valid;
  logic [1:0]          in_func;
  logic [AdcWidth-1:0] in_adc;
  logic                mid_valid;
  logic                out_valid;
  logic                out_en;
  logic                mid_en;
  logic                step;
  swp_snap_t           snap;
  swp_snap_t           res;
  logic [7:0]          seg_hundreds;
  logic [7:0]          seg_tens;
  logic [7:0]          seg_ones;

  assign out_en   = !out_valid || m_tready;
  assign mid_en   = !mid_valid || out_en;
  assign s_tready = !in_valid || mid_en;
  assign step     = in_valid && mid_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (mid_en) begin
        mid_valid <= in_valid;
      end
      if (out_en) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_adc  <= s_tdata[AdcWidth-1:0];
    end
  end

  swp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .func      (in_func),
    .adc_value (in_adc),
    .snap      (snap)
  );

  swp_disp u_disp (
    .clk          (clk),
    .load         (out_en && mid_valid),
    .snap         (snap),
    .res          (res),
    .seg_hundreds (seg_hundreds),
    .seg_tens     (seg_tens),
    .seg_ones     (seg_ones)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, seg_ones, seg_tens, seg_hundreds, res.setpoint,
                     res.busy, res.second, res.contactor, res.buzzer};

endmodule

// ----- tb/sv/swp_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swp_scoreboard
// Watches the item, result and register-write ports of the weld controller.
// Keeps its own copy of the weld sequence state, setpoint and timing
// registers. Works out the status that each accepted item should produce and
// compares every returned status, field by field, in order.
// ----------------------------------------------------------------------------
module swp_scoreboard import swp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [15:0]              s_tdata,
  input  logic [1:0]               s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [39:0]              m_tdata,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       checked,
  output int                       weld_runs
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WELD, ST_GAP, ST_PULSE, ST_HOLD
  } weld_phase_e;

  typedef struct {
    logic                     buzzer;
    logic                     contactor;
    logic                     pulse;
    logic                     busy;
    logic [SetpointWidth-1:0] setpoint;
    logic [7:0]               seg_h;
    logic [7:0]               seg_t;
    logic [7:0]               seg_o;
  } weld_status_t;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic [7:0]               offset_r;
  logic [3:0]               unit_r;
  logic [7:0]               gap_r;
  logic [7:0]               pulse_r;
  logic [11:0]              hold_r;

  weld_phase_e              phase;
  logic [CountWidth-1:0]    ticks_left;
  logic                     alt_skip;
  logic                     trig_latched;
  logic [SetpointWidth-1:0] setpoint;
  logic [7:0]               glyph [3];

  weld_status_t             expected_q [$];

  function automatic logic [CountWidth-1:0] phase_ticks(input weld_phase_e p);
    int prod;
    prod = int'(setpoint) * int'(unit_r);
    case (p)
      ST_WELD:  return prod[CountWidth-1:0];
      ST_GAP:   return CountWidth'(gap_r);
      ST_PULSE: return CountWidth'(pulse_r);
      ST_HOLD:  return CountWidth'(hold_r);
      default:  return '0;
    endcase
  endfunction

  // skip finished and empty phases; a latched trigger at the end of a run
  // only cancels the alternate skip that the run itself sets
  task automatic settle();
    while (phase != ST_IDLE && ticks_left == '0) begin
      if (phase == ST_HOLD) begin
        phase = ST_IDLE;
        if (trig_latched) begin
          trig_latched = 1'b0;
          alt_skip     = 1'b0;
        end else begin
          alt_skip = 1'b1;
        end
      end else begin
        phase      = weld_phase_e'(phase + 3'd1);
        ticks_left = phase_ticks(phase);
      end
    end
  endtask

  task automatic load_setpoint(input logic [AdcWidth-1:0] adc);
    int scaled;
    int v;
    scaled = (int'(adc) * 40) / 41;
    v = (scaled > int'(offset_r)) ? scaled - int'(offset_r) : 0;
    if (v > 999) v = 999;
    setpoint = SetpointWidth'(v);
    glyph[0] = DIGIT_GLYPH[(v / 100) % 10];
    glyph[1] = DIGIT_GLYPH[(v / 10) % 10];
    glyph[2] = DIGIT_GLYPH[v % 10];
  endtask

  task automatic apply_item(input logic [1:0] func, input logic [AdcWidth-1:0] adc);
    weld_status_t st;
    case (func)
      FUNC_SAMPLE: begin
        if (phase == ST_IDLE) load_setpoint(adc);
      end
      FUNC_TRIGGER: begin
        if (phase != ST_IDLE) begin
          trig_latched = 1'b1;
        end else if (!alt_skip) begin
          phase      = ST_WELD;
          ticks_left = phase_ticks(ST_WELD);
          weld_runs++;
          settle();
        end else begin
          alt_skip = 1'b0;
        end
      end
      FUNC_TICK: begin
        if (phase != ST_IDLE) begin
          if (ticks_left != '0) ticks_left = ticks_left - CountWidth'(1);
          settle();
        end
      end
      default: ;
    endcase
    st.buzzer    = (phase == ST_WELD);
    st.contactor = (phase != ST_WELD);
    st.pulse     = (phase == ST_PULSE);
    st.busy      = (phase != ST_IDLE);
    st.setpoint  = setpoint;
    st.seg_h     = glyph[0] & 8'h7F;
    st.seg_t     = glyph[1];
    st.seg_o     = glyph[2];
    expected_q.push_back(st);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    weld_status_t want;
    if (rst) begin
      errors       = 0;
      checked      = 0;
      weld_runs    = 0;
      offset_r     = RST_SAMPLE_OFFSET;
      unit_r       = RST_WELD_UNIT;
      gap_r        = RST_GAP;
      pulse_r      = RST_SECOND_PULSE;
      hold_r       = RST_HOLD;
      phase        = ST_IDLE;
      ticks_left   = '0;
      alt_skip     = 1'b0;
      trig_latched = 1'b0;
      setpoint     = '0;
      glyph[0]     = DIGIT_GLYPH[0];
      glyph[1]     = DIGIT_GLYPH[0];
      glyph[2]     = DIGIT_GLYPH[0];
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
        end else begin
          want = expected_q.pop_front();
          checked++;
          check_field("buzzer", int'(want.buzzer), int'(m_tdata[0]));
          check_field("contactor", int'(want.contactor), int'(m_tdata[1]));
          check_field("second", int'(want.pulse), int'(m_tdata[2]));
          check_field("busy", int'(want.busy), int'(m_tdata[3]));
          check_field("setpoint", int'(want.setpoint), int'(m_tdata[13:4]));
          check_field("seg_hundreds", int'(want.seg_h), int'(m_tdata[21:14]));
          check_field("seg_tens", int'(want.seg_t), int'(m_tdata[29:22]));
          check_field("seg_ones", int'(want.seg_o), int'(m_tdata[37:30]));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_OFFSET: offset_r = cfg_data[7:0];
          CFG_WELD_UNIT:     unit_r   = cfg_data[3:0];
          CFG_GAP:           gap_r    = cfg_data[7:0];
          CFG_SECOND_PULSE:  pulse_r  = cfg_data[7:0];
          CFG_HOLD:          hold_r   = cfg_data[11:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata[AdcWidth-1:0]);
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/sv/tb_spot_weld_pulse_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spot_weld_pulse_controller_core
// Stimulus and verdict for the spot-weld pulse controller core.
// A directed set covers setpoint scaling extremes, clamping, ignored samples,
// latched and alternate triggers and empty phases; random rounds then run
// weld sequences under several timing settings with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_spot_weld_pulse_controller_core;
  import swp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         CfgRegCount = 5;
  localparam int         StallLimit  = 5000;
  localparam int         Rounds      = 6;
  localparam int         RoundItems  = 100;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [15:0]              s_tdata;   // adc_value[9:0], zero pad
  logic [1:0]               s_tuser;   // func[1:0]
  logic                     m_tvalid;
  logic                     m_tready;
  logic [39:0]              m_tdata;   // buzzer, contactor, second, busy, setpoint[9:0],
                                       // seg_hundreds, seg_tens, seg_ones, pad
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  int errors;
  int pending;
  int checked;
  int weld_runs;
  int items_sent;
  int settings_used;
  int idle_cycles;
  int cur_offset;
  int stall_left;
  bit steady;

  spot_weld_pulse_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swp_scoreboard i_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .weld_runs (weld_runs)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no handshake for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [AdcWidth-1:0] adc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {6'b0, adc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every result is back, then let the pipe drain
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_timing(input logic [7:0] offset, input logic [3:0] unit,
                                input logic [7:0] gap, input logic [7:0] pulse,
                                input logic [11:0] hold);
    cur_offset = int'(offset);
    settings_used++;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_OFFSET;
    cfg_data  <= CfgDataWidth'(offset);
    @(posedge clk);
    cfg_index <= CFG_WELD_UNIT;
    cfg_data  <= CfgDataWidth'(unit);
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_data  <= CfgDataWidth'(gap);
    @(posedge clk);
    cfg_index <= CFG_SECOND_PULSE;
    cfg_data  <= CfgDataWidth'(pulse);
    @(posedge clk);
    cfg_index <= CFG_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= CfgIndexWidth'(CfgRegCount + $urandom_range(0, 2));
    cfg_data  <= CfgDataWidth'($urandom_range(0, 4095));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    int adc;
    r   = $urandom_range(0, 99);
    adc = $urandom_range(0, 1023);
    if (r < 6) begin
      send_item(FUNC_UNUSED, AdcWidth'(adc));
    end else if (r < 30) begin
      if ($urandom_range(0, 9) >= 3) begin
        adc = cur_offset + $urandom_range(0, 20);
        if (adc > 1023) adc = 1023;
      end
      send_item(FUNC_SAMPLE, AdcWidth'(adc));
    end else if (r < 44) begin
      send_item(FUNC_TRIGGER, AdcWidth'(adc));
    end else begin
      send_item(FUNC_TICK, AdcWidth'(adc));
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    cur_offset    = int'(RST_SAMPLE_OFFSET);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(FUNC_UNUSED, 10'h3FF);
    send_item(FUNC_TICK, 10'h000);
    send_item(FUNC_SAMPLE, 10'd0);
    send_item(FUNC_SAMPLE, 10'd1023);
    send_item(FUNC_SAMPLE, 10'd31);
    send_item(FUNC_SAMPLE, 10'd32);
    send_item(FUNC_SAMPLE, 10'h2AA);
    send_item(FUNC_SAMPLE, 10'h155);

    quiesce();
    program_timing(8'd0, 4'd1, 8'd1, 8'd1, 12'd1);
    send_item(FUNC_SAMPLE, 10'd3);
    send_item(FUNC_TRIGGER, 10'd0);
    send_item(FUNC_SAMPLE, 10'd1023);
    send_item(FUNC_TRIGGER, 10'd0);
    send_item(FUNC_TRIGGER, 10'd0);
    repeat (5) send_item(FUNC_TICK, 10'd0);
    send_item(FUNC_TRIGGER, 10'd0);
    repeat (5) send_item(FUNC_TICK, 10'd0);
    send_item(FUNC_TRIGGER, 10'd0);

    quiesce();
    program_timing(8'd0, 4'd0, 8'd0, 8'd0, 12'd0);
    send_item(FUNC_SAMPLE, 10'd1023);
    send_item(FUNC_TRIGGER, 10'd0);
    send_item(FUNC_TRIGGER, 10'd0);
    send_item(FUNC_TRIGGER, 10'd0);

    for (int rnd = 0; rnd < Rounds; rnd++) begin
      quiesce();
      if (rnd == 0) begin
        program_timing(8'd255, 4'd15, 8'd255, 8'd255, 12'd4095);
      end else if (rnd == 1) begin
        program_timing(8'd0, 4'd15, 8'd3, 8'd2, 12'd3);
      end else begin
        program_timing(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                       8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                       12'($urandom_range(0, 6)));
      end
      steady = (rnd == 3);
      for (int k = 0; k < RoundItems; k++) begin
        if (k == RoundItems / 2) quiesce();
        send_random();
      end
    end
    steady = 1'b0;

    quiesce();
    $display("Sent %0d items under %0d timing settings, checked %0d results.",
             items_sent, settings_used, checked);
    $display("Weld sequences started: %0d, mismatches: %0d.", weld_runs, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
